// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the pulse threshold feature extractor.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `ASSERT_ALWAYS(lbl, clk, rst, !(cond), msg)

`endif

// ===== hdl/ptfe_pkg.sv =====
// Package of the pulse threshold feature extractor: request and result types,
// the per-waveform summary passed from front to back, fixed constants.
package ptfe_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BIN_W      = 16;
  localparam int CHARGE_W   = 26;
  localparam int TIME_W     = 19;
  localparam int FRAC_W     = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHARGE_W-1:0] CHARGE_MAX = '1;
  localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
  localparam logic [TIME_W-1:0]   TIME_HALF  = TIME_W'(128);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_left;
    logic [SAMPLE_W-1:0] sample_right;
    logic                last_sample;
  } sample_req_t;

  typedef struct packed {
    logic [TIME_W-1:0]   time_left;
    logic [CHARGE_W-1:0] charge_left;
    logic [SAMPLE_W-1:0] peak_left;
    logic                found_left;
    logic [TIME_W-1:0]   time_right;
    logic [CHARGE_W-1:0] charge_right;
    logic [SAMPLE_W-1:0] peak_right;
    logic                found_right;
  } result_t;

  // one side of a finished waveform
  typedef struct packed {
    logic                found;
    logic [BIN_W-1:0]    cross_bin;
    logic [SAMPLE_W-1:0] below;
    logic [SAMPLE_W-1:0] above;
    logic [CHARGE_W-1:0] charge;
    logic [SAMPLE_W-1:0] peak;
  } side_sum_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    side_sum_t [1:0]     side;
  } wave_sum_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_FIN
  } back_state_t;

endpackage

// ===== hdl/ptfe_front.sv =====
// Front end: threshold register, per-bin discrimination, peak and charge
// accumulation; pushes one waveform summary per last sample. Uses ptfe_pkg.
module ptfe_front import ptfe_pkg::*; #(
  parameter int MAX_BINS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SAMPLE_W-1:0] cfg_data,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  sample_req_t         sample_data,
  input  queue_status_t       q_status,
  output logic                push,
  output wave_sum_t           push_data
);

  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= SAMPLE_W) ? '1 :
    SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] prev;
    logic [CHARGE_W-1:0] charge;
    logic [SAMPLE_W-1:0] peak;
    logic                seen;
    logic [BIN_W-1:0]    cbin;
    logic [SAMPLE_W-1:0] below;
    logic [SAMPLE_W-1:0] above;
  } side_acc_t;

  function automatic side_acc_t take_sample(side_acc_t s, logic [SAMPLE_W-1:0] v,
                                            logic [SAMPLE_W-1:0] thr,
                                            logic [BIN_W-1:0] bin);
    side_acc_t r;
    logic [CHARGE_W:0] sum;
    r = s;
    sum = {1'b0, s.charge} + (CHARGE_W+1)'(v - thr);
    if (v > thr) begin
      if (!s.seen) begin
        r.seen  = 1'b1;
        r.cbin  = bin;
        r.below = s.prev;
        r.above = v;
      end
      r.charge = sum[CHARGE_W] ? CHARGE_MAX : sum[CHARGE_W-1:0];
    end
    if (v > s.peak) r.peak = v;
    r.prev = v;
    return r;
  endfunction

  logic [SAMPLE_W-1:0] threshold;
  logic [CNT_W-1:0]    bin_index;
  side_acc_t [1:0]     acc;
  side_acc_t [1:0]     acc_next;
  logic [SAMPLE_W-1:0] smp [2];
  logic                adv;
  logic                accept;

  assign sample_stall = q_status.full;
  assign accept       = sample_valid && !sample_stall;
  assign adv          = bin_index < CNT_W'(MAX_BINS);
  assign smp[0]       = sample_data.sample_left & SAMPLE_MASK;
  assign smp[1]       = sample_data.sample_right & SAMPLE_MASK;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      acc_next[k] = adv ? take_sample(acc[k], smp[k], threshold, BIN_W'(bin_index)) : acc[k];
    end
  end

  always_comb begin
    push = accept && sample_data.last_sample;
    push_data.threshold = threshold;
    for (int k = 0; k < 2; k++) begin
      push_data.side[k].found     = acc_next[k].seen;
      push_data.side[k].cross_bin = acc_next[k].cbin;
      push_data.side[k].below     = acc_next[k].below;
      push_data.side[k].above     = acc_next[k].above;
      push_data.side[k].charge    = acc_next[k].charge;
      push_data.side[k].peak      = acc_next[k].peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_index <= '0;
      acc       <= '0;
    end else if (accept) begin
      if (sample_data.last_sample) begin
        bin_index <= '0;
        acc       <= '0;
      end else begin
        acc <= acc_next;
        if (adv) bin_index <= bin_index + CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/ptfe_queue.sv =====
// Short queue of waveform summaries between front and back end.
// Uses ptfe_pkg types and assert_macros.svh.
module ptfe_queue import ptfe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wave_sum_t     push_data,
  input  logic          pop,
  output wave_sum_t     head,
  output queue_status_t status
);

  `include "assert_macros.svh"

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  wave_sum_t        entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = count == CNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk, rst, push && status.full, "summary pushed into full queue")
  `ASSERT_NEVER(a_count_range, clk, rst, count > CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== hdl/ptfe_back.sv =====
// Back end: per waveform, an 8-step restoring division per side for the
// crossing fraction, time assembly and the result register. Uses ptfe_pkg.
module ptfe_back import ptfe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  wave_sum_t     head,
  input  queue_status_t q_status,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output result_t       result_data
);

  `include "assert_macros.svh"

  localparam int STEP_W = $clog2(FRAC_W);
  localparam int T_W    = BIN_W + FRAC_W + 1;

  back_state_t         state;
  back_state_t         state_next;
  logic [STEP_W-1:0]   step;
  logic                load_out;
  wave_sum_t           wave;
  logic [SAMPLE_W-1:0] rem [2];
  logic [SAMPLE_W-1:0] den [2];
  logic [FRAC_W-1:0]   quo [2];
  logic                div_en [2];
  logic [SAMPLE_W-1:0] den_in [2];
  logic [SAMPLE_W-1:0] num_in [2];
  logic [SAMPLE_W:0]   rem_sh [2];
  logic [TIME_W-1:0]   time_out [2];
  logic [T_W-1:0]      t_full [2];

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!q_status.empty) state_next = B_DIV;
      B_DIV:   if (step == STEP_W'(FRAC_W - 1)) state_next = B_FIN;
      B_FIN:   if (!result_valid || !result_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      B_IDLE:  pop = !q_status.empty;
      B_FIN:   load_out = !result_valid || !result_stall;
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      den_in[k] = (head.side[k].above > head.side[k].below) ?
                  head.side[k].above - head.side[k].below : '0;
      num_in[k] = (head.threshold > head.side[k].below) ?
                  head.threshold - head.side[k].below : '0;
      if (num_in[k] >= den_in[k]) num_in[k] = den_in[k] - SAMPLE_W'(1);
      rem_sh[k] = {rem[k], 1'b0};
      t_full[k] = T_W'({wave.side[k].cross_bin - BIN_W'(1), {FRAC_W{1'b0}}})
                + T_W'(TIME_HALF) + T_W'(div_en[k] ? quo[k] : '0);
      if (!wave.side[k].found) begin
        time_out[k] = '0;
      end else if (wave.side[k].cross_bin == '0) begin
        time_out[k] = TIME_HALF;
      end else if (t_full[k] > T_W'(TIME_MAX)) begin
        time_out[k] = TIME_MAX;
      end else begin
        time_out[k] = t_full[k][TIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (pop) step <= '0;
      else if (state == B_DIV) step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      if (pop) begin
        rem[k]    <= num_in[k];
        den[k]    <= den_in[k];
        div_en[k] <= head.side[k].above > head.side[k].below;
        quo[k]    <= '0;
      end else if (state == B_DIV) begin
        if (rem_sh[k] >= {1'b0, den[k]}) begin
          rem[k] <= SAMPLE_W'(rem_sh[k] - {1'b0, den[k]});
          quo[k] <= {quo[k][FRAC_W-2:0], 1'b1};
        end else begin
          rem[k] <= rem_sh[k][SAMPLE_W-1:0];
          quo[k] <= {quo[k][FRAC_W-2:0], 1'b0};
        end
      end
    end
    if (pop) wave <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_data.time_left    <= time_out[0];
      result_data.charge_left  <= wave.side[0].charge;
      result_data.peak_left    <= wave.side[0].peak;
      result_data.found_left   <= wave.side[0].found;
      result_data.time_right   <= time_out[1];
      result_data.charge_right <= wave.side[1].charge;
      result_data.peak_right   <= wave.side[1].peak;
      result_data.found_right  <= wave.side[1].found;
    end
  end

  `ASSERT_ALWAYS(a_rem_below_den, clk, rst,
    state == B_DIV && div_en[0] |-> rem[0] < den[0], "division remainder not below divisor")
  `ASSERT_ALWAYS(a_no_cross_empty, clk, rst,
    result_valid && !result_data.found_left |->
      result_data.time_left == '0 && result_data.charge_left == '0,
    "no crossing but time or charge set")
  `ASSERT_ALWAYS(a_found_time, clk, rst,
    result_valid && result_data.found_right |-> result_data.time_right >= TIME_HALF,
    "crossing time below half bin")

endmodule

// ===== hdl/pulse_threshold_feature_extractor.sv =====
// Top level of the pulse threshold feature extractor: front end, summary queue
// and back end. Depends on ptfe_pkg, ptfe_front, ptfe_queue and ptfe_back.
//
//   channel   direction  handshake                 payload
//   sample    in         sample_valid/sample_stall sample_req_t (one bin, both sides)
//   result    out        result_valid/result_stall result_t (one per waveform)
//   config    in         cfg_we                    cfg_data (threshold)
//
// One sample pair is taken per cycle; only a full summary queue stalls the input.
// Per waveform the back end pops the queue, runs 8 fraction steps of the divider
// and loads the result before its next pop; faster waveforms fill the 2-entry queue.
// Reset is synchronous; it clears threshold, accumulators, queue pointers, back-end control.
// The result register holds under result_stall while the next division runs.
module pulse_threshold_feature_extractor import ptfe_pkg::*; #(
  parameter int MAX_BINS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SAMPLE_W-1:0] cfg_data,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  sample_req_t         sample_data,
  output logic                result_valid,
  input  logic                result_stall,
  output result_t             result_data
);

  logic          push;
  logic          pop;
  wave_sum_t     push_data;
  wave_sum_t     head;
  queue_status_t q_status;

  ptfe_front #(
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  ptfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  ptfe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
